FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the wheel speed mixer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define DD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

FILE: hdl/ddwsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddwsm_pkg
// Widths, reset values, register codes and pipeline payload types.
// ----------------------------------------------------------------------------
package ddwsm_pkg;

  localparam int CmdFracBits = 14;
  localparam int CmdW        = 16;
  localparam int ClampW      = CmdFracBits + 1;
  localparam int ScaleFrac   = 16;

  localparam int MaxLinW    = 16;
  localparam int MaxAngW    = 24;
  localparam int HalfTrackW = 16;
  localparam int InvRadW    = 24;
  localparam int DeadbandW  = 15;
  localparam int DampW      = 16;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  localparam int RateW = 24;

  localparam int DampProdW = CmdW + DampW;
  localparam int LinProdW  = CmdFracBits + MaxLinW;
  localparam int AngProdW  = CmdFracBits + MaxAngW;
  localparam int VMagW     = MaxLinW;
  localparam int WMagW     = MaxAngW;
  localparam int OffsProdW = WMagW + HalfTrackW;
  localparam int OffsW     = WMagW;
  localparam int WheelW    = OffsW + 2;
  localparam int WheelMagW = OffsW + 1;
  localparam int NumW      = WheelMagW + MaxLinW;
  localparam int QuoW      = MaxLinW;
  localparam int DivisorW  = WheelMagW + 1;
  localparam int DivW      = NumW + 1;
  localparam int RateProdW = QuoW + InvRadW;

  localparam logic [CmdW-1:0]      CmdOne  = CmdW'(1) << CmdFracBits;
  localparam logic [DampProdW-1:0] DampRnd = DampProdW'(1) << (ScaleFrac - 1);
  localparam logic [LinProdW-1:0]  LinRnd  = LinProdW'(1) << (CmdFracBits - 1);
  localparam logic [AngProdW-1:0]  AngRnd  = AngProdW'(1) << (CmdFracBits - 1);
  localparam logic [OffsProdW-1:0] OffsRnd = OffsProdW'(1) << (ScaleFrac - 1);
  localparam logic [RateProdW-1:0] RateRnd = RateProdW'(1) << (ScaleFrac - 1);

  localparam logic [RateW-1:0] RatePosMax = {1'b0, {(RateW - 1){1'b1}}};
  localparam logic [RateW-1:0] RateNegMin = {1'b1, {(RateW - 1){1'b0}}};

  localparam logic [MaxLinW-1:0]    MaxLinRst    = 16'd23724;
  localparam logic [MaxAngW-1:0]    MaxAngRst    = 24'd237240;
  localparam logic [HalfTrackW-1:0] HalfTrackRst = 16'd6554;
  localparam logic [InvRadW-1:0]    InvRadRst    = 24'd1894102;
  localparam logic [DeadbandW-1:0]  DeadbandRst  = 15'd164;
  localparam logic [DampW-1:0]      DampRst      = 16'd52429;

  localparam logic [CfgIdxW-1:0] CfgMaxLinSpeed = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxAngSpeed = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgHalfTrack   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgInvRadius   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDeadband    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDamping     = 3'd5;

  typedef struct packed {
    logic [MaxLinW-1:0]    max_linear_speed;
    logic [MaxAngW-1:0]    max_angular_speed;
    logic [HalfTrackW-1:0] half_track_width;
    logic [InvRadW-1:0]    inverse_wheel_radius;
    logic [DeadbandW-1:0]  spin_deadband;
    logic [DampW-1:0]      spin_damping;
  } cfg_t;

  // Scaled commands before rounding.
  typedef struct packed {
    logic                lin_neg;
    logic                ang_neg;
    logic [LinProdW-1:0] lin_prod;
    logic [AngProdW-1:0] ang_prod;
  } scaled_t;

  // Wheel speeds with limiter numerators.
  typedef struct packed {
    logic                 limited;
    logic                 right_neg;
    logic                 left_neg;
    logic [WheelMagW-1:0] mx;
    logic [NumW-1:0]      right_num;
    logic [NumW-1:0]      left_num;
    logic [QuoW-1:0]      right_mag;
    logic [QuoW-1:0]      left_mag;
  } wheel_t;

  // Final wheel linear speed magnitudes.
  typedef struct packed {
    logic            limited;
    logic            right_neg;
    logic            left_neg;
    logic [QuoW-1:0] right_mag;
    logic [QuoW-1:0] left_mag;
  } lim_t;

endpackage

FILE: hdl/ddwsm_cmd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddwsm_cmd
// Command front end: spin damping, clamping and scaling to physical units.
// ----------------------------------------------------------------------------
module ddwsm_cmd (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ddwsm_pkg::cfg_t                cfg_i,
  input  logic                           vld_i,
  output logic                           rdy_o,
  input  logic [ddwsm_pkg::CmdW-1:0]     linear_command_i,
  input  logic [ddwsm_pkg::CmdW-1:0]     angular_command_i,
  output logic                           vld_o,
  input  logic                           rdy_i,
  output ddwsm_pkg::scaled_t             scaled_o
);

  logic en1, en2, en3;
  logic s1_vld_q, s2_vld_q, s3_vld_q;

  // stage 1
  logic                                lin_neg, ang_neg, damp_on;
  logic [ddwsm_pkg::CmdW-1:0]          lin_mag, ang_mag;
  logic [ddwsm_pkg::DampProdW-1:0]     damp_prod;
  logic                                s1_lin_neg_q, s1_ang_neg_q, s1_damp_q;
  logic [ddwsm_pkg::CmdW-1:0]          s1_lin_mag_q, s1_ang_mag_q;
  logic [ddwsm_pkg::DampProdW-1:0]     s1_prod_q;

  // stage 2
  logic [ddwsm_pkg::DampProdW-1:0]     damp_sum;
  logic [ddwsm_pkg::CmdW-1:0]          ang_sel;
  logic [ddwsm_pkg::ClampW-1:0]        lin_clamp, ang_clamp;
  logic                                s2_lin_neg_q, s2_ang_neg_q;
  logic [ddwsm_pkg::ClampW-1:0]        s2_lin_q, s2_ang_q;

  // stage 3
  logic [ddwsm_pkg::LinProdW-1:0]      lin_prod;
  logic [ddwsm_pkg::AngProdW-1:0]      ang_prod;
  ddwsm_pkg::scaled_t                  s3_q;

  assign en3   = !s3_vld_q || rdy_i;
  assign en2   = !s2_vld_q || en3;
  assign en1   = !s1_vld_q || en2;
  assign rdy_o = en1;
  assign vld_o = s3_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      if (en1) s1_vld_q <= vld_i;
      if (en2) s2_vld_q <= s1_vld_q;
      if (en3) s3_vld_q <= s2_vld_q;
    end
  end

  always_comb begin
    lin_neg   = linear_command_i[ddwsm_pkg::CmdW-1];
    ang_neg   = angular_command_i[ddwsm_pkg::CmdW-1];
    lin_mag   = lin_neg ? (~linear_command_i + 1'b1) : linear_command_i;
    ang_mag   = ang_neg ? (~angular_command_i + 1'b1) : angular_command_i;
    damp_on   = lin_mag < {{(ddwsm_pkg::CmdW - ddwsm_pkg::DeadbandW){1'b0}},
                           cfg_i.spin_deadband};
    damp_prod = {{(ddwsm_pkg::DampProdW - ddwsm_pkg::CmdW){1'b0}}, ang_mag} *
                {{(ddwsm_pkg::DampProdW - ddwsm_pkg::DampW){1'b0}}, cfg_i.spin_damping};
  end

  always_comb begin
    damp_sum  = s1_prod_q + ddwsm_pkg::DampRnd;
    ang_sel   = s1_damp_q ? damp_sum[ddwsm_pkg::ScaleFrac +: ddwsm_pkg::CmdW] : s1_ang_mag_q;
    // clamp magnitudes to one
    lin_clamp = (s1_lin_mag_q > ddwsm_pkg::CmdOne) ? ddwsm_pkg::CmdOne[ddwsm_pkg::ClampW-1:0]
                                                   : s1_lin_mag_q[ddwsm_pkg::ClampW-1:0];
    ang_clamp = (ang_sel > ddwsm_pkg::CmdOne) ? ddwsm_pkg::CmdOne[ddwsm_pkg::ClampW-1:0]
                                              : ang_sel[ddwsm_pkg::ClampW-1:0];
  end

  always_comb begin
    lin_prod = {{(ddwsm_pkg::LinProdW - ddwsm_pkg::ClampW){1'b0}}, s2_lin_q} *
               {{(ddwsm_pkg::LinProdW - ddwsm_pkg::MaxLinW){1'b0}}, cfg_i.max_linear_speed};
    ang_prod = {{(ddwsm_pkg::AngProdW - ddwsm_pkg::ClampW){1'b0}}, s2_ang_q} *
               {{(ddwsm_pkg::AngProdW - ddwsm_pkg::MaxAngW){1'b0}}, cfg_i.max_angular_speed};
  end

  always_ff @(posedge clk_i) begin
    if (en1 && vld_i) begin
      s1_lin_neg_q <= lin_neg;
      s1_ang_neg_q <= ang_neg;
      s1_damp_q    <= damp_on;
      s1_lin_mag_q <= lin_mag;
      s1_ang_mag_q <= ang_mag;
      s1_prod_q    <= damp_prod;
    end
    if (en2 && s1_vld_q) begin
      s2_lin_neg_q <= s1_lin_neg_q;
      s2_ang_neg_q <= s1_ang_neg_q;
      s2_lin_q     <= lin_clamp;
      s2_ang_q     <= ang_clamp;
    end
    if (en3 && s2_vld_q) begin
      s3_q.lin_neg  <= s2_lin_neg_q;
      s3_q.ang_neg  <= s2_ang_neg_q;
      s3_q.lin_prod <= lin_prod;
      s3_q.ang_prod <= ang_prod;
    end
  end

  assign scaled_o = s3_q;

endmodule

FILE: hdl/ddwsm_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddwsm_mix
// Wheel mixing: track offset, right and left speeds, limiter check.
// ----------------------------------------------------------------------------
module ddwsm_mix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ddwsm_pkg::cfg_t    cfg_i,
  input  logic               vld_i,
  output logic               rdy_o,
  input  ddwsm_pkg::scaled_t scaled_i,
  output logic               vld_o,
  input  logic               rdy_i,
  output ddwsm_pkg::wheel_t  wheel_o
);

  logic en4, en5, en6;
  logic s4_vld_q, s5_vld_q, s6_vld_q;

  // stage 4
  logic [ddwsm_pkg::LinProdW-1:0]  lin_sum;
  logic [ddwsm_pkg::AngProdW-1:0]  ang_sum;
  logic [ddwsm_pkg::WMagW-1:0]     w_mag;
  logic [ddwsm_pkg::OffsProdW-1:0] offs_prod;
  logic                            s4_lin_neg_q, s4_ang_neg_q;
  logic [ddwsm_pkg::VMagW-1:0]     s4_v_q;
  logic [ddwsm_pkg::OffsProdW-1:0] s4_offs_q;

  // stage 5
  logic [ddwsm_pkg::OffsProdW-1:0] offs_sum;
  logic [ddwsm_pkg::WheelW-1:0]    v_ext, o_ext, v_sgn, o_sgn;
  logic [ddwsm_pkg::WheelW-1:0]    s5_right_q, s5_left_q;

  // stage 6
  logic                            right_neg, left_neg, limited;
  logic [ddwsm_pkg::WheelW-1:0]    right_abs, left_abs;
  logic [ddwsm_pkg::WheelMagW-1:0] right_mag, left_mag, mx;
  logic [ddwsm_pkg::NumW-1:0]      right_num, left_num;
  ddwsm_pkg::wheel_t               s6_q;

  assign en6   = !s6_vld_q || rdy_i;
  assign en5   = !s5_vld_q || en6;
  assign en4   = !s4_vld_q || en5;
  assign rdy_o = en4;
  assign vld_o = s6_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
    end else begin
      if (en4) s4_vld_q <= vld_i;
      if (en5) s5_vld_q <= s4_vld_q;
      if (en6) s6_vld_q <= s5_vld_q;
    end
  end

  always_comb begin
    lin_sum   = scaled_i.lin_prod + ddwsm_pkg::LinRnd;
    ang_sum   = scaled_i.ang_prod + ddwsm_pkg::AngRnd;
    w_mag     = ang_sum[ddwsm_pkg::CmdFracBits +: ddwsm_pkg::WMagW];
    offs_prod = {{(ddwsm_pkg::OffsProdW - ddwsm_pkg::WMagW){1'b0}}, w_mag} *
                {{(ddwsm_pkg::OffsProdW - ddwsm_pkg::HalfTrackW){1'b0}},
                 cfg_i.half_track_width};
  end

  always_comb begin
    offs_sum = s4_offs_q + ddwsm_pkg::OffsRnd;
    v_ext    = {{(ddwsm_pkg::WheelW - ddwsm_pkg::VMagW){1'b0}}, s4_v_q};
    o_ext    = {{(ddwsm_pkg::WheelW - ddwsm_pkg::OffsW){1'b0}},
                offs_sum[ddwsm_pkg::ScaleFrac +: ddwsm_pkg::OffsW]};
    v_sgn    = s4_lin_neg_q ? (~v_ext + 1'b1) : v_ext;
    o_sgn    = s4_ang_neg_q ? (~o_ext + 1'b1) : o_ext;
  end

  always_comb begin
    right_neg = s5_right_q[ddwsm_pkg::WheelW-1];
    left_neg  = s5_left_q[ddwsm_pkg::WheelW-1];
    right_abs = right_neg ? (~s5_right_q + 1'b1) : s5_right_q;
    left_abs  = left_neg ? (~s5_left_q + 1'b1) : s5_left_q;
    right_mag = right_abs[ddwsm_pkg::WheelMagW-1:0];
    left_mag  = left_abs[ddwsm_pkg::WheelMagW-1:0];
    mx        = (right_mag > left_mag) ? right_mag : left_mag;
    limited   = mx > {{(ddwsm_pkg::WheelMagW - ddwsm_pkg::MaxLinW){1'b0}},
                      cfg_i.max_linear_speed};
    right_num = {{(ddwsm_pkg::NumW - ddwsm_pkg::WheelMagW){1'b0}}, right_mag} *
                {{(ddwsm_pkg::NumW - ddwsm_pkg::MaxLinW){1'b0}}, cfg_i.max_linear_speed};
    left_num  = {{(ddwsm_pkg::NumW - ddwsm_pkg::WheelMagW){1'b0}}, left_mag} *
                {{(ddwsm_pkg::NumW - ddwsm_pkg::MaxLinW){1'b0}}, cfg_i.max_linear_speed};
  end

  always_ff @(posedge clk_i) begin
    if (en4 && vld_i) begin
      s4_lin_neg_q <= scaled_i.lin_neg;
      s4_ang_neg_q <= scaled_i.ang_neg;
      s4_v_q       <= lin_sum[ddwsm_pkg::CmdFracBits +: ddwsm_pkg::VMagW];
      s4_offs_q    <= offs_prod;
    end
    if (en5 && s4_vld_q) begin
      s5_right_q <= v_sgn + o_sgn;
      s5_left_q  <= v_sgn - o_sgn;
    end
    if (en6 && s5_vld_q) begin
      s6_q.limited   <= limited;
      s6_q.right_neg <= right_neg;
      s6_q.left_neg  <= left_neg;
      s6_q.mx        <= mx;
      s6_q.right_num <= right_num;
      s6_q.left_num  <= left_num;
      // unlimited wheels never exceed the speed limit width
      s6_q.right_mag <= right_mag[ddwsm_pkg::QuoW-1:0];
      s6_q.left_mag  <= left_mag[ddwsm_pkg::QuoW-1:0];
    end
  end

  assign wheel_o = s6_q;

endmodule

FILE: hdl/ddwsm_div.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// ddwsm_div
// Pipelined restoring divider, one quotient bit per stage, two wheel lanes.
// ----------------------------------------------------------------------------
module ddwsm_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ddwsm_pkg::MaxLinW-1:0] max_lin_i,
  input  logic                          vld_i,
  output logic                          rdy_o,
  input  ddwsm_pkg::wheel_t             wheel_i,
  output logic                          vld_o,
  input  logic                          rdy_i,
  output ddwsm_pkg::lim_t               lim_o
);

  localparam int Last = ddwsm_pkg::QuoW;

  logic [Last+1:0] en;
  logic [Last:0]   vld_q;
  logic [Last:0]   lim_q, rneg_q, lneg_q;

  logic [ddwsm_pkg::DivisorW-1:0] rem_r_q [Last+1];
  logic [ddwsm_pkg::DivisorW-1:0] rem_l_q [Last+1];
  logic [ddwsm_pkg::DivisorW-1:0] e_q     [Last+1];
  logic [ddwsm_pkg::QuoW-1:0]     low_r_q [Last+1];
  logic [ddwsm_pkg::QuoW-1:0]     low_l_q [Last+1];
  logic [ddwsm_pkg::QuoW-1:0]     q_r_q   [Last+1];
  logic [ddwsm_pkg::QuoW-1:0]     q_l_q   [Last+1];
  logic [ddwsm_pkg::QuoW-1:0]     mag_r_q [Last+1];
  logic [ddwsm_pkg::QuoW-1:0]     mag_l_q [Last+1];

  logic [ddwsm_pkg::DivW-1:0] d_r, d_l;

  assign en[Last+1] = rdy_i;
  for (genvar k = 0; k <= Last; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end
  assign rdy_o = en[0];
  assign vld_o = vld_q[Last];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= vld_i;
      for (int k = 1; k <= Last; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // round(num / mx) as floor((2 num + mx) / (2 mx))
  always_comb begin
    d_r = {wheel_i.right_num, 1'b0} +
          {{(ddwsm_pkg::DivW - ddwsm_pkg::WheelMagW){1'b0}}, wheel_i.mx};
    d_l = {wheel_i.left_num, 1'b0} +
          {{(ddwsm_pkg::DivW - ddwsm_pkg::WheelMagW){1'b0}}, wheel_i.mx};
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && vld_i) begin
      lim_q[0]   <= wheel_i.limited;
      rneg_q[0]  <= wheel_i.right_neg;
      lneg_q[0]  <= wheel_i.left_neg;
      e_q[0]     <= {wheel_i.mx, 1'b0};
      rem_r_q[0] <= d_r[ddwsm_pkg::DivW-1 -: ddwsm_pkg::DivisorW];
      rem_l_q[0] <= d_l[ddwsm_pkg::DivW-1 -: ddwsm_pkg::DivisorW];
      low_r_q[0] <= d_r[ddwsm_pkg::QuoW-1:0];
      low_l_q[0] <= d_l[ddwsm_pkg::QuoW-1:0];
      q_r_q[0]   <= '0;
      q_l_q[0]   <= '0;
      mag_r_q[0] <= wheel_i.right_mag;
      mag_l_q[0] <= wheel_i.left_mag;
    end
  end

  for (genvar k = 1; k <= Last; k++) begin : g_step
    logic [ddwsm_pkg::DivisorW:0] t_r, t_l, e_x, sub_r, sub_l;
    logic                         ge_r, ge_l;

    always_comb begin
      // bring down the next dividend bit and try a subtract
      t_r   = {rem_r_q[k-1], low_r_q[k-1][ddwsm_pkg::QuoW-1]};
      t_l   = {rem_l_q[k-1], low_l_q[k-1][ddwsm_pkg::QuoW-1]};
      e_x   = {1'b0, e_q[k-1]};
      ge_r  = t_r >= e_x;
      ge_l  = t_l >= e_x;
      sub_r = t_r - e_x;
      sub_l = t_l - e_x;
    end

    always_ff @(posedge clk_i) begin
      if (en[k] && vld_q[k-1]) begin
        lim_q[k]   <= lim_q[k-1];
        rneg_q[k]  <= rneg_q[k-1];
        lneg_q[k]  <= lneg_q[k-1];
        e_q[k]     <= e_q[k-1];
        rem_r_q[k] <= ge_r ? sub_r[ddwsm_pkg::DivisorW-1:0] : t_r[ddwsm_pkg::DivisorW-1:0];
        rem_l_q[k] <= ge_l ? sub_l[ddwsm_pkg::DivisorW-1:0] : t_l[ddwsm_pkg::DivisorW-1:0];
        low_r_q[k] <= {low_r_q[k-1][ddwsm_pkg::QuoW-2:0], 1'b0};
        low_l_q[k] <= {low_l_q[k-1][ddwsm_pkg::QuoW-2:0], 1'b0};
        q_r_q[k]   <= {q_r_q[k-1][ddwsm_pkg::QuoW-2:0], ge_r};
        q_l_q[k]   <= {q_l_q[k-1][ddwsm_pkg::QuoW-2:0], ge_l};
        mag_r_q[k] <= mag_r_q[k-1];
        mag_l_q[k] <= mag_l_q[k-1];
      end
    end
  end

  always_comb begin
    lim_o.limited   = lim_q[Last];
    lim_o.right_neg = rneg_q[Last];
    lim_o.left_neg  = lneg_q[Last];
    lim_o.right_mag = lim_q[Last] ? q_r_q[Last] : mag_r_q[Last];
    lim_o.left_mag  = lim_q[Last] ? q_l_q[Last] : mag_l_q[Last];
  end

  `DD_ASSERT(a_div_rem_bound, (vld_q[Last] && lim_q[Last]) |-> ((rem_r_q[Last] < e_q[Last]) && (rem_l_q[Last] < e_q[Last])), "divider remainder out of range")
  `DD_ASSERT(a_div_peak_at_limit, (vld_q[Last] && lim_q[Last]) |-> ((q_r_q[Last] == max_lin_i) || (q_l_q[Last] == max_lin_i)), "larger limited wheel not at speed limit")

endmodule

FILE: hdl/ddwsm_rate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddwsm_rate
// Wheel angular rate: inverse radius product, rounding, saturation, output.
// ----------------------------------------------------------------------------
module ddwsm_rate (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ddwsm_pkg::cfg_t             cfg_i,
  input  logic                        vld_i,
  output logic                        rdy_o,
  input  ddwsm_pkg::lim_t             lim_i,
  output logic                        vld_o,
  input  logic                        rdy_i,
  output logic [ddwsm_pkg::RateW-1:0] left_rate_o,
  output logic [ddwsm_pkg::RateW-1:0] right_rate_o,
  output logic                        limited_o
);

  logic en1, en2;
  logic s1_vld_q, s2_vld_q;

  logic [ddwsm_pkg::RateProdW-1:0] prod_r, prod_l;
  logic                            s1_lim_q, s1_rneg_q, s1_lneg_q;
  logic [ddwsm_pkg::RateProdW-1:0] s1_prod_r_q, s1_prod_l_q;

  logic [ddwsm_pkg::RateProdW-1:0] sum_r, sum_l;
  logic [ddwsm_pkg::RateW-1:0]     mag_r, mag_l, rate_r, rate_l;
  logic [ddwsm_pkg::RateW-1:0]     s2_left_q, s2_right_q;
  logic                            s2_lim_q;

  assign en2   = !s2_vld_q || rdy_i;
  assign en1   = !s1_vld_q || en2;
  assign rdy_o = en1;
  assign vld_o = s2_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (en1) s1_vld_q <= vld_i;
      if (en2) s2_vld_q <= s1_vld_q;
    end
  end

  always_comb begin
    prod_r = {{(ddwsm_pkg::RateProdW - ddwsm_pkg::QuoW){1'b0}}, lim_i.right_mag} *
             {{(ddwsm_pkg::RateProdW - ddwsm_pkg::InvRadW){1'b0}}, cfg_i.inverse_wheel_radius};
    prod_l = {{(ddwsm_pkg::RateProdW - ddwsm_pkg::QuoW){1'b0}}, lim_i.left_mag} *
             {{(ddwsm_pkg::RateProdW - ddwsm_pkg::InvRadW){1'b0}}, cfg_i.inverse_wheel_radius};
  end

  always_comb begin
    sum_r = s1_prod_r_q + ddwsm_pkg::RateRnd;
    sum_l = s1_prod_l_q + ddwsm_pkg::RateRnd;
    mag_r = sum_r[ddwsm_pkg::ScaleFrac +: ddwsm_pkg::RateW];
    mag_l = sum_l[ddwsm_pkg::ScaleFrac +: ddwsm_pkg::RateW];
    // saturate on the magnitude, the negative side reaches one step further
    if (s1_rneg_q) begin
      rate_r = (mag_r > ddwsm_pkg::RateNegMin) ? ddwsm_pkg::RateNegMin : (~mag_r + 1'b1);
    end else begin
      rate_r = (mag_r > ddwsm_pkg::RatePosMax) ? ddwsm_pkg::RatePosMax : mag_r;
    end
    if (s1_lneg_q) begin
      rate_l = (mag_l > ddwsm_pkg::RateNegMin) ? ddwsm_pkg::RateNegMin : (~mag_l + 1'b1);
    end else begin
      rate_l = (mag_l > ddwsm_pkg::RatePosMax) ? ddwsm_pkg::RatePosMax : mag_l;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && vld_i) begin
      s1_lim_q    <= lim_i.limited;
      s1_rneg_q   <= lim_i.right_neg;
      s1_lneg_q   <= lim_i.left_neg;
      s1_prod_r_q <= prod_r;
      s1_prod_l_q <= prod_l;
    end
    if (en2 && s1_vld_q) begin
      s2_lim_q   <= s1_lim_q;
      s2_right_q <= rate_r;
      s2_left_q  <= rate_l;
    end
  end

  assign left_rate_o  = s2_left_q;
  assign right_rate_o = s2_right_q;
  assign limited_o    = s2_lim_q;

endmodule

FILE: hdl/diff_drive_wheel_speed_mixer.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Flow: an accepted command runs through the command, mixing, divider and rate stages.
// Throughput: one item per cycle without output stalls; every stage is a single register
// level and the limiter divider resolves one quotient bit per stage over 16 stages.
// Stalls hold each stage in place; empty stages keep taking items behind them.
// Reset: asynchronous, active low; empties the pipeline and loads default registers.
// ----------------------------------------------------------------------------
// diff_drive_wheel_speed_mixer
// Differential drive inverse kinematics with speed limiting, fully pipelined.
// ----------------------------------------------------------------------------
module diff_drive_wheel_speed_mixer (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [ddwsm_pkg::CmdW-1:0]     linear_command_i,
  input  logic signed [ddwsm_pkg::CmdW-1:0]     angular_command_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [ddwsm_pkg::RateW-1:0]    left_wheel_rate_o,
  output logic signed [ddwsm_pkg::RateW-1:0]    right_wheel_rate_o,
  output logic                                  speed_limited_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ddwsm_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [ddwsm_pkg::CfgDataW-1:0]        cfg_data_i
);

  ddwsm_pkg::cfg_t    cfg_q;
  ddwsm_pkg::scaled_t scaled;
  ddwsm_pkg::wheel_t  wheel;
  ddwsm_pkg::lim_t    lim;

  logic cmd_rdy, cmd_vld, mix_rdy, mix_vld, div_rdy, div_vld, rate_rdy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_linear_speed     <= ddwsm_pkg::MaxLinRst;
      cfg_q.max_angular_speed    <= ddwsm_pkg::MaxAngRst;
      cfg_q.half_track_width     <= ddwsm_pkg::HalfTrackRst;
      cfg_q.inverse_wheel_radius <= ddwsm_pkg::InvRadRst;
      cfg_q.spin_deadband        <= ddwsm_pkg::DeadbandRst;
      cfg_q.spin_damping         <= ddwsm_pkg::DampRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        ddwsm_pkg::CfgMaxLinSpeed:
          cfg_q.max_linear_speed <= cfg_data_i[ddwsm_pkg::MaxLinW-1:0];
        ddwsm_pkg::CfgMaxAngSpeed:
          cfg_q.max_angular_speed <= cfg_data_i[ddwsm_pkg::MaxAngW-1:0];
        ddwsm_pkg::CfgHalfTrack:
          cfg_q.half_track_width <= cfg_data_i[ddwsm_pkg::HalfTrackW-1:0];
        ddwsm_pkg::CfgInvRadius:
          cfg_q.inverse_wheel_radius <= cfg_data_i[ddwsm_pkg::InvRadW-1:0];
        ddwsm_pkg::CfgDeadband:
          cfg_q.spin_deadband <= cfg_data_i[ddwsm_pkg::DeadbandW-1:0];
        ddwsm_pkg::CfgDamping:
          cfg_q.spin_damping <= cfg_data_i[ddwsm_pkg::DampW-1:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  ddwsm_cmd u_cmd (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .vld_i             (in_valid_i),
    .rdy_o             (cmd_rdy),
    .linear_command_i  (linear_command_i),
    .angular_command_i (angular_command_i),
    .vld_o             (cmd_vld),
    .rdy_i             (mix_rdy),
    .scaled_o          (scaled)
  );

  ddwsm_mix u_mix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .vld_i    (cmd_vld),
    .rdy_o    (mix_rdy),
    .scaled_i (scaled),
    .vld_o    (mix_vld),
    .rdy_i    (div_rdy),
    .wheel_o  (wheel)
  );

  ddwsm_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .max_lin_i (cfg_q.max_linear_speed),
    .vld_i     (mix_vld),
    .rdy_o     (div_rdy),
    .wheel_i   (wheel),
    .vld_o     (div_vld),
    .rdy_i     (rate_rdy),
    .lim_o     (lim)
  );

  ddwsm_rate u_rate (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .vld_i        (div_vld),
    .rdy_o        (rate_rdy),
    .lim_i        (lim),
    .vld_o        (out_valid_o),
    .rdy_i        (!out_stall_i),
    .left_rate_o  (left_wheel_rate_o),
    .right_rate_o (right_wheel_rate_o),
    .limited_o    (speed_limited_o)
  );

  assign in_stall_o = !cmd_rdy;

  `DD_ASSERT(a_no_stall_when_drained, (!out_valid_o || !out_stall_i) |-> !in_stall_o, "input stalled while output side can move")

endmodule

FILE: dv/wheel_rate_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wheel_rate_checker
// Mirrors the mixer's registers from the configuration port, works out the
// wheel rates of every accepted command and compares them, field by field,
// with the rates that leave the block, in order.
// ----------------------------------------------------------------------------
module wheel_rate_checker
  import ddwsm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic signed [CmdW-1:0]  linear_command_i,
  input  logic signed [CmdW-1:0]  angular_command_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic signed [RateW-1:0] left_wheel_rate_i,
  input  logic signed [RateW-1:0] right_wheel_rate_i,
  input  logic                    speed_limited_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [CfgDataW-1:0]     cfg_data_i,
  output int                      mismatch_count_o,
  output int                      rates_outstanding_o
);

  typedef struct packed {
    logic signed [RateW-1:0] left_rate;
    logic signed [RateW-1:0] right_rate;
    logic                    limited;
  } wheel_rates_t;

  cfg_t         regs;
  wheel_rates_t expected_rates_q[$];

  function automatic longint unsigned magnitude(longint x);
    return (x < 0) ? -x : x;
  endfunction

  // Exact product, then round half away from zero on the magnitude.
  function automatic longint scale_round(longint x, longint unsigned k, int unsigned sh);
    longint unsigned r;
    r = (magnitude(x) * k + (64'd1 << (sh - 1))) >> sh;
    return (x < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint ratio_round(longint x, longint unsigned num,
                                         longint unsigned den);
    longint unsigned r;
    r = (magnitude(x) * num * 64'd2 + den) / (den * 64'd2);
    return (x < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clamp_unit(longint x);
    longint one;
    one = longint'(1) << CmdFracBits;
    if (x > one) return one;
    if (x < -one) return -one;
    return x;
  endfunction

  function automatic logic signed [RateW-1:0] wheel_rate(longint wheel,
                                                         longint unsigned inv_radius);
    longint r;
    r = scale_round(wheel, inv_radius, ScaleFrac);
    if (r > 64'sd8388607) r = 64'sd8388607;
    if (r < -64'sd8388608) r = -64'sd8388608;
    return r[RateW-1:0];
  endfunction

  function automatic wheel_rates_t predict_rates(cfg_t c, logic signed [CmdW-1:0] lin_cmd,
                                                 logic signed [CmdW-1:0] ang_cmd);
    longint          lin, ang, v, w, offs, right, left;
    longint unsigned mx;
    wheel_rates_t    res;
    lin = longint'(lin_cmd);
    ang = longint'(ang_cmd);
    res.limited = 1'b0;
    // Deadband looks at the raw linear command; damping comes before the clamp.
    if (magnitude(lin) < 64'(c.spin_deadband)) begin
      ang = scale_round(ang, 64'(c.spin_damping), ScaleFrac);
    end
    lin = clamp_unit(lin);
    ang = clamp_unit(ang);
    v = scale_round(lin, 64'(c.max_linear_speed), CmdFracBits);
    w = scale_round(ang, 64'(c.max_angular_speed), CmdFracBits);
    offs = scale_round(w, 64'(c.half_track_width), ScaleFrac);
    right = v + offs;
    left = v - offs;
    mx = (magnitude(right) > magnitude(left)) ? magnitude(right) : magnitude(left);
    if (mx > 64'(c.max_linear_speed)) begin
      right = ratio_round(right, 64'(c.max_linear_speed), mx);
      left = ratio_round(left, 64'(c.max_linear_speed), mx);
      res.limited = 1'b1;
    end
    res.left_rate = wheel_rate(left, 64'(c.inverse_wheel_radius));
    res.right_rate = wheel_rate(right, 64'(c.inverse_wheel_radius));
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    wheel_rates_t want;
    if (!rst_ni) begin
      regs.max_linear_speed = MaxLinRst;
      regs.max_angular_speed = MaxAngRst;
      regs.half_track_width = HalfTrackRst;
      regs.inverse_wheel_radius = InvRadRst;
      regs.spin_deadband = DeadbandRst;
      regs.spin_damping = DampRst;
      expected_rates_q.delete();
      mismatch_count_o = 0;
      rates_outstanding_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgMaxLinSpeed: regs.max_linear_speed = cfg_data_i[MaxLinW-1:0];
          CfgMaxAngSpeed: regs.max_angular_speed = cfg_data_i[MaxAngW-1:0];
          CfgHalfTrack:   regs.half_track_width = cfg_data_i[HalfTrackW-1:0];
          CfgInvRadius:   regs.inverse_wheel_radius = cfg_data_i[InvRadW-1:0];
          CfgDeadband:    regs.spin_deadband = cfg_data_i[DeadbandW-1:0];
          CfgDamping:     regs.spin_damping = cfg_data_i[DampW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        expected_rates_q.push_back(predict_rates(regs, linear_command_i, angular_command_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_rates_q.size() == 0) begin
          $error("wheel rates with no command pending: left %0d right %0d limited %0b",
                 left_wheel_rate_i, right_wheel_rate_i, speed_limited_i);
          mismatch_count_o++;
        end else begin
          want = expected_rates_q.pop_front();
          if (left_wheel_rate_i !== want.left_rate) begin
            $error("left_wheel_rate: expected %0d, actual %0d",
                   $signed(want.left_rate), left_wheel_rate_i);
            mismatch_count_o++;
          end
          if (right_wheel_rate_i !== want.right_rate) begin
            $error("right_wheel_rate: expected %0d, actual %0d",
                   $signed(want.right_rate), right_wheel_rate_i);
            mismatch_count_o++;
          end
          if (speed_limited_i !== want.limited) begin
            $error("speed_limited: expected %0b, actual %0b", want.limited, speed_limited_i);
            mismatch_count_o++;
          end
        end
      end
      rates_outstanding_o = expected_rates_q.size();
    end
  end

endmodule

FILE: dv/diff_drive_wheel_speed_mixer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_wheel_speed_mixer_tb
// Drives velocity commands and register settings into the wheel speed mixer
// with random gaps and stalls on both sides; the checker beside the block
// predicts and compares every set of wheel rates.
// ----------------------------------------------------------------------------
module diff_drive_wheel_speed_mixer_tb;
  import ddwsm_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnusedLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgUnusedHi = 3'd7;
  localparam int LongHoldCycles = 150;
  localparam int DrainCycles    = 40;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [CmdW-1:0]  linear_command = '0;
  logic signed [CmdW-1:0]  angular_command = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [RateW-1:0] left_wheel_rate;
  logic signed [RateW-1:0] right_wheel_rate;
  logic                    speed_limited;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CfgIdxW-1:0]      cfg_index = '0;
  logic [CfgDataW-1:0]     cfg_data = '0;

  int   mismatch_count;
  int   rates_outstanding;
  int   deadband_now = int'(DeadbandRst);
  logic tx_eager = 1'b0;
  logic rx_eager = 1'b0;
  logic long_hold_req = 1'b0;

  diff_drive_wheel_speed_mixer u_top (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .linear_command_i   (linear_command),
    .angular_command_i  (angular_command),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .left_wheel_rate_o  (left_wheel_rate),
    .right_wheel_rate_o (right_wheel_rate),
    .speed_limited_o    (speed_limited),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data)
  );

  wheel_rate_checker u_checker (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_i          (in_stall),
    .linear_command_i    (linear_command),
    .angular_command_i   (angular_command),
    .out_valid_i         (out_valid),
    .out_stall_i         (out_stall),
    .left_wheel_rate_i   (left_wheel_rate),
    .right_wheel_rate_i  (right_wheel_rate),
    .speed_limited_i     (speed_limited),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_i         (cfg_ready),
    .cfg_index_i         (cfg_index),
    .cfg_data_i          (cfg_data),
    .mismatch_count_o    (mismatch_count),
    .rates_outstanding_o (rates_outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Receiver: random stall before each item, eager stretches, one long hold-off on request.
  initial begin : receiver
    int stall_cycles;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_eager = !rx_eager;
      if (long_hold_req) begin
        stall_cycles = LongHoldCycles;
        long_hold_req = 1'b0;
      end else if (rx_eager) begin
        stall_cycles = 0;
      end else begin
        stall_cycles = $urandom_range(0, 3);
      end
      @(negedge clk);
      if (stall_cycles != 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_command(input logic signed [CmdW-1:0] lin,
                              input logic signed [CmdW-1:0] ang);
    int gap;
    if ($urandom_range(0, 15) == 0) tx_eager = !tx_eager;
    gap = tx_eager ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    linear_command <= lin;
    angular_command <= ang;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and hold until every command has come back.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (rates_outstanding != 0) @(negedge clk);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                input logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_settings(input logic [CfgDataW-1:0] max_lin, max_ang, half_track,
                                  inv_radius, deadband, damping);
    write_register(CfgMaxLinSpeed, max_lin);
    write_register(CfgMaxAngSpeed, max_ang);
    write_register(CfgHalfTrack, half_track);
    write_register(CfgInvRadius, inv_radius);
    write_register(CfgDeadband, deadband);
    write_register(CfgDamping, damping);
    deadband_now = int'(deadband[DeadbandW-1:0]);
  endtask

  function automatic int corner_command(int k);
    case (k)
      0: return 0;
      1: return 1;
      2: return -1;
      3: return 16384;
      4: return -16384;
      5: return 16385;
      6: return -32768;
      default: return 32767;
    endcase
  endfunction

  task automatic run_random(input int count);
    int sel;
    int lin, ang;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) lin = int'($urandom_range(0, 2 * deadband_now)) - deadband_now;
      else if (sel < 30) lin = $urandom;
      else if (sel < 40) lin = corner_command($urandom_range(0, 7));
      else lin = int'($urandom_range(0, 32768)) - 16384;
      sel = $urandom_range(0, 99);
      if (sel < 20) ang = $urandom;
      else if (sel < 30) ang = corner_command($urandom_range(0, 7));
      else ang = int'($urandom_range(0, 32768)) - 16384;
      send_command(lin[CmdW-1:0], ang[CmdW-1:0]);
    end
  endtask

  initial begin : stimulus
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    program_settings(CfgDataW'(MaxLinRst), CfgDataW'(MaxAngRst), CfgDataW'(HalfTrackRst),
                     CfgDataW'(InvRadRst), CfgDataW'(DeadbandRst), CfgDataW'(DampRst));
    send_command(0, 0);
    send_command(16384, 0);           // wheel exactly at the limit
    send_command(16384, 1);           // just past the limit
    send_command(0, 16384);           // spin in place, damped
    send_command(-16384, 0);
    send_command(32767, 32767);       // both clamp
    send_command(-32768, -32768);
    send_command(16385, -16385);
    send_command(16384, -16384);
    send_command(-16384, 16384);
    send_command(163, 16384);         // inside deadband
    send_command(164, 16384);         // on the deadband edge, not damped
    send_command(-163, -32768);       // damped, then clamped
    send_command(-164, -20000);
    send_command(0, -32768);
    send_command(16'h5555, 16'hAAAA);
    send_command(16'hAAAA, 16'h5555);
    send_command(100, 32767);
    send_command(-8192, 4096);
    send_command(12000, -3000);
    wait_idle();

    // Zero speed limit: every moving wheel scales to zero.
    program_settings(24'd0, CfgDataW'(MaxAngRst), CfgDataW'(HalfTrackRst),
                     CfgDataW'(InvRadRst), CfgDataW'(DeadbandRst), CfgDataW'(DampRst));
    send_command(0, 0);
    send_command(16384, 0);
    send_command(0, 16384);
    send_command(-5000, 3000);
    wait_idle();

    program_settings(24'hFFFF, 24'hFF_FFFF, 24'hFFFF, 24'hFF_FFFF, 24'd16384, 24'hFFFF);
    run_random(50);
    wait_idle();

    program_settings(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
    run_random(25);
    wait_idle();

    // Oversized values keep only the low bits; unused indexes change nothing.
    program_settings(24'h12_5C3A, 24'h04_0000, 24'hAB_1999, 24'h1C_E6D6, 24'hFF_FFFF,
                     24'h77_C000);
    write_register(CfgUnusedLo, CfgDataW'($urandom));
    write_register(CfgUnusedHi, CfgDataW'($urandom));
    run_random(40);
    wait_idle();

    for (int p = 0; p < 5; p++) begin
      if (p % 2 == 0) begin
        program_settings(CfgDataW'($urandom_range(1000, 65535)),
                         CfgDataW'($urandom_range(0, 1 << 20)),
                         CfgDataW'($urandom_range(0, 65535)),
                         CfgDataW'($urandom_range(0, 1 << 22)),
                         CfgDataW'($urandom_range(0, 16384)),
                         CfgDataW'($urandom_range(0, 65535)));
      end else begin
        program_settings(CfgDataW'($urandom), CfgDataW'($urandom), CfgDataW'($urandom),
                         CfgDataW'($urandom), CfgDataW'($urandom), CfgDataW'($urandom));
      end
      if (p == 2) begin
        // Fill the pipeline behind a long output stall.
        tx_eager = 1'b1;
        long_hold_req = 1'b1;
        run_random(100);
      end else begin
        run_random(50);
      end
      wait_idle();
    end

    repeat (DrainCycles) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
